### sv/nppe_pkg.sv
// Shared types and constants for the banked NAND page program/erase unit.
// Holds array geometry, operation and status codes, and the transaction structs.
// Depends on nothing; every other file but nppe_ram imports it.
`default_nettype none

package nppe_pkg;

  // Array geometry.
  localparam int NUM_BANKS       = 4;
  localparam int BLOCKS_PER_BANK = 8;
  localparam int PAGES_PER_BLOCK = 32;

  // Index widths; bank and block bits are concatenated to address a block.
  localparam int BANK_W      = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int BLK_W       = (BLOCKS_PER_BANK > 1) ? $clog2(BLOCKS_PER_BANK) : 1;
  localparam int BIDX_W      = BANK_W + BLK_W;
  localparam int PAGE_W      = $clog2(PAGES_PER_BLOCK);
  localparam int ADDR_W      = BIDX_W + PAGE_W;
  localparam int FILL_DEPTH  = 2 ** BIDX_W;
  localparam int PAGE_DEPTH  = 2 ** ADDR_W;
  localparam int FILL_W      = $clog2(PAGES_PER_BLOCK + 1);
  localparam int WORD_W      = 32;

  // Range limits, sized one bit wider than the index fields.
  localparam logic [8:0] BANK_LIM  = 9'(NUM_BANKS);
  localparam logic [8:0] BLOCK_LIM = 9'(BLOCKS_PER_BANK);
  localparam logic [8:0] PAGE_LIM  = 9'(PAGES_PER_BLOCK);

  // Depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_PROGRAM = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_ERASE   = 2'd2,
    FUNC_NOP     = 2'd3
  } nppe_func_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_BANK     = 3'd1,
    ST_BAD_BLOCK    = 3'd2,
    ST_BAD_PAGE     = 3'd3,
    ST_PAGE_WRITTEN = 3'd4,
    ST_OUT_OF_ORDER = 3'd5,
    ST_READ_EMPTY   = 3'd6,
    ST_ERASE_FREE   = 3'd7
  } nppe_status_t;

  // Command transaction as it arrives.
  typedef struct packed {
    nppe_func_t        func;
    logic [7:0]        bank_index;
    logic [7:0]        block_index;
    logic [7:0]        page_index;
    logic [WORD_W-1:0] write_word;
    logic [WORD_W-1:0] write_spare;
  } nppe_cmd_t;

  // Result transaction.
  typedef struct packed {
    nppe_status_t      status;
    logic [WORD_W-1:0] read_word;
    logic [WORD_W-1:0] read_spare;
  } nppe_rsp_t;

  // Classified command, as held in the queue.
  typedef struct packed {
    nppe_func_t        op;
    nppe_status_t      pre;
    logic [BIDX_W-1:0] bidx;
    logic [PAGE_W-1:0] page;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] spare;
  } nppe_job_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic      valid;
    nppe_job_t job;
  } nppe_slot_t;

endpackage

`default_nettype wire

### sv/nppe_ram.sv
// Generic single-port RAM with registered read data.
// Used for the page data and spare stores; no package dependency.
`default_nettype none

module nppe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one read per cycle; read data appears after the edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### sv/nppe_front.sv
// Front end: range checks a command and reduces it to a queued job.
// Depends on nppe_pkg for the geometry and the transaction types.
`default_nettype none

module nppe_front import nppe_pkg::*; (
  input  wire nppe_cmd_t cmd,
  output nppe_job_t      job
);

  logic bank_bad;
  logic block_bad;
  logic page_bad;

  assign bank_bad  = {1'b0, cmd.bank_index}  >= BANK_LIM;
  assign block_bad = {1'b0, cmd.block_index} >= BLOCK_LIM;
  assign page_bad  = {1'b0, cmd.page_index}  >= PAGE_LIM;

  // Address checks run in order: bank, block, then page (not for erase); a nop is not checked.
  always_comb begin
    job.op    = cmd.func;
    job.bidx  = {cmd.bank_index[BANK_W-1:0], cmd.block_index[BLK_W-1:0]};
    job.page  = cmd.page_index[PAGE_W-1:0];
    job.word  = cmd.write_word;
    job.spare = cmd.write_spare;
    priority if (cmd.func == FUNC_NOP) begin
      job.pre = ST_OK;
    end else if (bank_bad) begin
      job.pre = ST_BAD_BANK;
    end else if (block_bad) begin
      job.pre = ST_BAD_BLOCK;
    end else if (cmd.func != FUNC_ERASE && page_bad) begin
      job.pre = ST_BAD_PAGE;
    end else begin
      job.pre = ST_OK;
    end
  end

endmodule

`default_nettype wire

### sv/nppe_queue.sv
// Short FIFO of classified jobs between the front and back ends.
// Depends on nppe_pkg for the job and slot types and the queue depth.
`default_nettype none

module nppe_queue import nppe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire nppe_job_t push_job,
  input  wire logic      pop,
  output logic           full,
  output nppe_slot_t     head
);

  nppe_job_t         entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign do_push    = push && !full;
  assign do_pop     = pop && count != '0;
  assign head.valid = count != '0;
  assign head.job   = entry[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/nppe_back.sv
// Back end: checks the block fill count, updates it and accesses the page stores.
// Depends on nppe_pkg and on nppe_ram for the data and spare stores.
`default_nettype none

module nppe_back import nppe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire nppe_slot_t slot,
  output logic            pop,
  output logic            done,
  output nppe_rsp_t       rsp
);

  logic [FILL_W-1:0] fill [FILL_DEPTH];
  logic [FILL_W-1:0] fill_cur;
  logic [FILL_W-1:0] fill_new;
  logic [FILL_W-1:0] page_ext;
  logic              fill_we;
  logic              ram_we;
  logic              ram_re;
  logic              rd_ok;
  nppe_status_t      status;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] spare_q;
  logic              res_valid;
  logic              res_rd;
  nppe_status_t      res_status;

  assign pop      = slot.valid;
  assign fill_cur = fill[slot.job.bidx];
  assign page_ext = FILL_W'(slot.job.page);
  assign ram_addr = {slot.job.bidx, slot.job.page};

  // Decide the outcome against the current fill count of the block.
  always_comb begin
    status   = slot.job.pre;
    fill_we  = 1'b0;
    fill_new = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    rd_ok    = 1'b0;
    if (slot.valid && slot.job.pre == ST_OK) begin
      unique case (slot.job.op)
        FUNC_PROGRAM: begin
          if (page_ext < fill_cur) begin
            status = ST_PAGE_WRITTEN;
          end else if (page_ext > fill_cur) begin
            status = ST_OUT_OF_ORDER;
          end else begin
            ram_we   = 1'b1;
            fill_we  = 1'b1;
            fill_new = fill_cur + 1'b1;
          end
        end
        FUNC_READ: begin
          if (page_ext < fill_cur) begin
            ram_re = 1'b1;
            rd_ok  = 1'b1;
          end else begin
            status = ST_READ_EMPTY;
          end
        end
        FUNC_ERASE: begin
          if (fill_cur == '0) begin
            status = ST_ERASE_FREE;
          end else begin
            fill_we = 1'b1;
          end
        end
        FUNC_NOP: begin
          status = ST_OK;
        end
      endcase
    end
  end

  // Fill counts; reset empties every block at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILL_DEPTH; i++) begin
        fill[i] <= '0;
      end
    end else if (fill_we) begin
      fill[slot.job.bidx] <= fill_new;
    end
  end

  nppe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PAGE_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (slot.job.word),
    .rdata (data_q)
  );

  nppe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PAGE_DEPTH)
  ) u_spare_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (slot.job.spare),
    .rdata (spare_q)
  );

  // Result register, aligned with the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      res_rd     <= 1'b0;
      res_status <= ST_OK;
    end else begin
      res_valid  <= slot.valid;
      res_rd     <= rd_ok;
      res_status <= status;
    end
  end

  assign done           = res_valid;
  assign rsp.status     = res_status;
  assign rsp.read_word  = res_rd ? data_q : '0;
  assign rsp.read_spare = res_rd ? spare_q : '0;

endmodule

`default_nettype wire

### sv/nand_page_program_erase_model_unit.sv
// Top level of the banked NAND page program/erase unit.
// Depends on nppe_pkg, nppe_front, nppe_queue and nppe_back.
//
//   Channel   Handshake            Payload      Transaction taken when
//   command   start / busy         cmd          start high and busy low at the edge
//   result    done (strobe)        rsp          done high; one cycle only
//
// A taken command is first written into the queue; the back end then reads and writes
// the fill count of its block and accesses the page store, and the result is registered
// together with the read data out of the store.
// The back end retires one queued transaction per cycle, so one command per cycle
// is sustained; busy rises only when the two-entry queue is full.
// Reset empties every block at once; page stores are not cleared.
// The receiver cannot stall, so done is never held.
`default_nettype none

module nand_page_program_erase_model_unit import nppe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire nppe_cmd_t cmd,
  output logic           done,
  output nppe_rsp_t      rsp
);

  nppe_job_t  job;
  nppe_slot_t head;
  logic       full;
  logic       pop;
  logic       accept;

  assign busy   = full;
  assign accept = start && !busy;

  nppe_front u_front (
    .cmd (cmd),
    .job (job)
  );

  nppe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_job (job),
    .pop      (pop),
    .full     (full),
    .head     (head)
  );

  nppe_back u_back (
    .clk  (clk),
    .rst  (rst),
    .slot (head),
    .pop  (pop),
    .done (done),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

### sv/nppe_checker.sv
// Port-level checks for the NAND page program/erase unit, bound to its top level.
// Depends on nppe_pkg for the transaction types and status codes.
`default_nettype none

module nppe_checker import nppe_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done,
  input wire nppe_rsp_t rsp
);

  // No result strobe straight after reset.
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // Every taken command is answered, through the queue and the back-end result register.
  a_accept_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("command not answered in two cycles");

  // No result appears without a command taken before it, through the queue and the result register.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a command");

  // Read data is only returned with a good status.
  a_data_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.read_word == '0 && rsp.read_spare == '0))
    else $error("read data on a failed transaction");

endmodule

bind nand_page_program_erase_model_unit nppe_checker u_checker (.*);

`default_nettype wire

### bench/nand_page_program_erase_model_unit_tb.sv
// Self-checking bench for the banked NAND page program/erase unit.
// A scoreboard class predicts each result, and plain tasks drive the command port.
// Depends on nppe_pkg and nand_page_program_erase_model_unit.

module nand_page_program_erase_model_unit_tb;
  import nppe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BLOCKS = NUM_BANKS * BLOCKS_PER_BANK;
  localparam int TOTAL_PAGES  = TOTAL_BLOCKS * PAGES_PER_BLOCK;

  // Predicts the array's answers and holds the results still owed by the unit.
  class nand_array_scoreboard;
    int unsigned       fill [TOTAL_BLOCKS];
    logic [WORD_W-1:0] data_mem [TOTAL_PAGES];
    logic [WORD_W-1:0] spare_mem [TOTAL_PAGES];
    nppe_rsp_t         pending_rsp [$];
    int                errors;
    int                taken;
    int                checked;
    int                status_seen [8];

    function new();
      foreach (fill[i]) fill[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      errors  = 0;
      taken   = 0;
      checked = 0;
    endfunction

    // Applies one accepted command to the shadow array and queues its answer.
    function void note_command(nppe_cmd_t c);
      nppe_rsp_t   r;
      int unsigned b;
      int unsigned f;
      int unsigned a;
      r.status     = ST_OK;
      r.read_word  = '0;
      r.read_spare = '0;
      taken++;
      if (c.func == FUNC_NOP) begin
        r.status = ST_OK;
      end else if (c.bank_index >= NUM_BANKS) begin
        r.status = ST_BAD_BANK;
      end else if (c.block_index >= BLOCKS_PER_BANK) begin
        r.status = ST_BAD_BLOCK;
      end else begin
        b = c.bank_index * BLOCKS_PER_BANK + c.block_index;
        f = fill[b];
        if (c.func == FUNC_ERASE) begin
          // An erase looks only at the fill count, never at the page.
          if (f == 0) r.status = ST_ERASE_FREE;
          else fill[b] = 0;
        end else if (c.page_index >= PAGES_PER_BLOCK) begin
          r.status = ST_BAD_PAGE;
        end else begin
          a = b * PAGES_PER_BLOCK + c.page_index;
          if (c.func == FUNC_PROGRAM) begin
            if (c.page_index < f) begin
              r.status = ST_PAGE_WRITTEN;
            end else if (c.page_index > f) begin
              r.status = ST_OUT_OF_ORDER;
            end else begin
              data_mem[a]  = c.write_word;
              spare_mem[a] = c.write_spare;
              fill[b]      = f + 1;
            end
          end else if (c.page_index < f) begin
            r.read_word  = data_mem[a];
            r.read_spare = spare_mem[a];
          end else begin
            r.status = ST_READ_EMPTY;
          end
        end
      end
      pending_rsp.push_back(r);
    endfunction

    // Compares one result, field by field, with the oldest prediction.
    function void check_result(nppe_rsp_t got);
      nppe_rsp_t want;
      checked++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d word %h spare %h",
                 $time, got.status, got.read_word, got.read_spare);
        return;
      end
      want = pending_rsp.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
      if (got.read_word !== want.read_word) begin
        errors++;
        $display("%0t: read_word mismatch, expected %h, actual %h",
                 $time, want.read_word, got.read_word);
      end
      if (got.read_spare !== want.read_spare) begin
        errors++;
        $display("%0t: read_spare mismatch, expected %h, actual %h",
                 $time, want.read_spare, got.read_spare);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  nppe_cmd_t cmd = '0;
  logic      done;
  nppe_rsp_t rsp;

  nand_array_scoreboard sb = new();
  int unsigned sender_idle_pct = 6;
  int unsigned hot_blocks [3];

  nand_page_program_erase_model_unit uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  always #4 clk = ~clk;

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(rsp);
      if (start && !busy) sb.note_command(cmd);
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("nand_page_program_erase_model_unit regression: fail");
    $finish;
  end

  function automatic nppe_cmd_t cmd_of(nppe_func_t fn, logic [7:0] bank, logic [7:0] blk,
                                       logic [7:0] page, logic [31:0] w, logic [31:0] s);
    nppe_cmd_t c;
    c.func        = fn;
    c.bank_index  = bank;
    c.block_index = blk;
    c.page_index  = page;
    c.write_word  = w;
    c.write_spare = s;
    return c;
  endfunction

  // Moves to the next falling edge, idling there at random with junk on cmd.
  task automatic idle_gap();
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      cmd   <= cmd_of(nppe_func_t'(2'($urandom)), 8'($urandom), 8'($urandom),
                      8'($urandom), $urandom, $urandom);
      @(negedge clk);
    end
  endtask

  // Presents a transaction at the current falling edge and holds it until taken.
  task automatic drive(input nppe_cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send(input nppe_cmd_t c);
    idle_gap();
    drive(c);
  endtask

  initial begin
    nppe_cmd_t   c;
    int unsigned roll;
    int unsigned b;
    int unsigned f;
    logic [7:0]  bank;
    logic [7:0]  blk;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every status, check order, field extremes and the unused code.
    send(cmd_of(FUNC_READ,    8'd0,   8'd0,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_ERASE,   8'd0,   8'd0,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_PROGRAM, 8'd0,   8'd0,   8'd0,   32'h0000_0000, 32'hFFFF_FFFF));
    send(cmd_of(FUNC_PROGRAM, 8'd0,   8'd0,   8'd0,   32'h1111_1111, 32'h2222_2222));
    send(cmd_of(FUNC_PROGRAM, 8'd0,   8'd0,   8'd2,   32'h3333_3333, 32'h4444_4444));
    send(cmd_of(FUNC_PROGRAM, 8'd0,   8'd0,   8'd1,   32'hFFFF_FFFF, 32'h0000_0000));
    send(cmd_of(FUNC_READ,    8'd0,   8'd0,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_READ,    8'd0,   8'd0,   8'd1,   32'h0, 32'h0));
    send(cmd_of(FUNC_READ,    8'd0,   8'd0,   8'd2,   32'h0, 32'h0));
    send(cmd_of(FUNC_PROGRAM, 8'd4,   8'd0,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_READ,    8'd255, 8'd255, 8'd255, 32'h0, 32'h0));
    send(cmd_of(FUNC_PROGRAM, 8'd3,   8'd8,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_ERASE,   8'd0,   8'd255, 8'd255, 32'h0, 32'h0));
    send(cmd_of(FUNC_READ,    8'd0,   8'd0,   8'd32,  32'h0, 32'h0));
    send(cmd_of(FUNC_PROGRAM, 8'd3,   8'd7,   8'd255, 32'h0, 32'h0));
    send(cmd_of(FUNC_PROGRAM, 8'd3,   8'd7,   8'd0,   32'hA5A5_A5A5, 32'h5A5A_5A5A));
    send(cmd_of(FUNC_READ,    8'd3,   8'd7,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_ERASE,   8'd0,   8'd0,   8'd255, 32'h0, 32'h0));
    send(cmd_of(FUNC_ERASE,   8'd0,   8'd0,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_READ,    8'd0,   8'd0,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_NOP,     8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(cmd_of(FUNC_NOP,     8'd1,   8'd2,   8'd3,   32'h0, 32'h0));
    send(cmd_of(FUNC_ERASE,   8'd255, 8'd0,   8'd0,   32'h0, 32'h0));
    send(cmd_of(FUNC_PROGRAM, 8'd0,   8'd0,   8'd0,   32'h1234_5678, 32'h9ABC_DEF0));
    send(cmd_of(FUNC_READ,    8'd0,   8'd0,   8'd0,   32'h0, 32'h0));

    // Random: three idle profiles, each opening with one block filled to the top.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 69 : 0;
      foreach (hot_blocks[i]) hot_blocks[i] = $urandom_range(TOTAL_BLOCKS - 1);

      b    = hot_blocks[0];
      bank = 8'(b / BLOCKS_PER_BANK);
      blk  = 8'(b % BLOCKS_PER_BANK);
      idle_gap();
      while (sb.fill[b] < PAGES_PER_BLOCK) begin
        drive(cmd_of(FUNC_PROGRAM, bank, blk, 8'(sb.fill[b]), $urandom, $urandom));
        idle_gap();
      end
      drive(cmd_of(FUNC_PROGRAM, bank, blk, 8'($urandom_range(PAGES_PER_BLOCK - 1)),
                   $urandom, $urandom));
      send(cmd_of(FUNC_READ, bank, blk, 8'(PAGES_PER_BLOCK - 1), $urandom, $urandom));

      for (int n = 0; n < 100; n++) begin
        idle_gap();
        roll = $urandom_range(99);
        b = ($urandom_range(3) != 0) ? hot_blocks[$urandom_range(2)]
                                     : $urandom_range(TOTAL_BLOCKS - 1);
        f = sb.fill[b];
        c = cmd_of(FUNC_PROGRAM, 8'(b / BLOCKS_PER_BANK), 8'(b % BLOCKS_PER_BANK), 8'(f),
                   $urandom, $urandom);
        if (roll < 45) begin
          // Program at the fill position; a full block yields a bad page.
        end else if (roll < 70) begin
          c.func       = FUNC_READ;
          c.page_index = (f == 0) ? 8'($urandom_range(PAGES_PER_BLOCK - 1))
                                  : 8'($urandom_range(f - 1));
        end else if (roll < 74) begin
          c.func       = FUNC_ERASE;
          c.page_index = 8'($urandom);
        end else if (roll < 86) begin
          // Program or read anywhere in range: written, out of order, empty.
          c.func       = nppe_func_t'(2'($urandom_range(1)));
          c.page_index = 8'($urandom_range(PAGES_PER_BLOCK - 1));
        end else if (roll < 93) begin
          c.func        = nppe_func_t'(2'($urandom));
          c.block_index = 8'($urandom);
          c.page_index  = 8'($urandom);
        end else begin
          c = cmd_of(nppe_func_t'(2'($urandom)), 8'($urandom), 8'($urandom),
                     8'($urandom), $urandom, $urandom);
        end
        drive(c);
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain the predicted results, then wait on with some margin.
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Covered %0d commands under three idle profiles; %0d results checked.",
             sb.taken, sb.checked);
    $display("Statuses: ok %0d, bad bank %0d, bad block %0d, bad page %0d, written %0d,",
             sb.status_seen[ST_OK], sb.status_seen[ST_BAD_BANK],
             sb.status_seen[ST_BAD_BLOCK], sb.status_seen[ST_BAD_PAGE],
             sb.status_seen[ST_PAGE_WRITTEN]);
    $display("  out of order %0d, read empty %0d, erase free %0d",
             sb.status_seen[ST_OUT_OF_ORDER], sb.status_seen[ST_READ_EMPTY],
             sb.status_seen[ST_ERASE_FREE]);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("nand_page_program_erase_model_unit regression: pass");
    end else begin
      $display("nand_page_program_erase_model_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/nppe_pkg.sv
sv/nppe_ram.sv
sv/nppe_front.sv
sv/nppe_queue.sv
sv/nppe_back.sv
sv/nand_page_program_erase_model_unit.sv
sv/nppe_checker.sv
bench/nand_page_program_erase_model_unit_tb.sv
